// ===== src/psrp_pkg.sv =====
`timescale 1ns / 1ps
package psrp_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_TICK   = 3'd1,
    CMD_FENTER = 3'd2,
    CMD_FEXIT  = 3'd3,
    CMD_COLL   = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BELOW = 2'd1,
    ST_FULL  = 2'd2,
    ST_DUP   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_TICK,
    OP_FTICK,
    OP_FENTER,
    OP_READ
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LB,
    S_LBCMP,
    S_CHK,
    S_USE,
    S_SHRD,
    S_SHWR,
    S_FIN
  } state_t;

endpackage

// ===== src/psrp_mem.sv =====
`timescale 1ns / 1ps
module psrp_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 128
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/pc_sample_region_profiler.sv =====
`timescale 1ns / 1ps
// Channel | Beat fields                                   | Handshake
// in      | cmd, address, entry_index                      | in_valid / in_ready
// out     | status, hit_index, tick_count, foreign_enters, | out_valid / out_ready
//         | foreign_ticks, collector_enters, collector_ticks|
// One command at a time; all region state sits in one single-port-read RAM.
// Tick / foreign enter / load: a binary search, a RAM read then a compare per step
// (about log2(count + 1) steps), then a check; no floor, duplicate or full goes
// straight to the result, a counted hit first writes its update (S_USE), and an
// insert first shifts: it reads and writes each entry moved up (count - position).
// Read, foreign tick: RAM read, then S_USE, then result. Exit, toggle, collector tick: result only.
// Reset is synchronous; RAM needs no clearing. A stalled out beat lets one more
// command run; its result then waits in the final state with in_ready low.
module pc_sample_region_profiler #(
  parameter int REGIONS    = 256,
  parameter int ADDR_BITS  = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            cmd,
  input  logic [31:0]           address,
  input  logic [7:0]            entry_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output psrp_pkg::status_t     status,
  output logic [7:0]            hit_index,
  output logic [31:0]           tick_count,
  output logic [31:0]           foreign_enters,
  output logic [31:0]           foreign_ticks,
  output logic [31:0]           collector_enters,
  output logic [31:0]           collector_ticks
);

  import psrp_pkg::*;

  localparam int IW = $clog2(REGIONS);
  localparam int CW = $clog2(REGIONS + 1);
  localparam int CB = COUNT_BITS;
  localparam int W  = ADDR_BITS + 3 * CB;

  state_t state, state_next;
  op_t op;
  logic [ADDR_BITS-1:0] addr_q;
  logic [CW-1:0] lo, hi, sh, region_count;
  logic [IW-1:0] pos, foreign_target;
  logic in_foreign, collector_active;
  logic [CB-1:0] gc_enter_total, gc_tick_total;
  status_t res_status;
  logic [7:0] res_hit;
  logic [CB-1:0] res_t, res_fe, res_ft;

  logic rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [W-1:0] rd_data, wr_data;

  logic [ADDR_BITS-1:0] r_start;
  logic [CB-1:0] r_t, r_fe, r_ft, n_t, n_fe, n_ft;
  logic [CW-1:0] mid;
  logic lb_eq, out_free, accept, idx_ok, tgt_ok;

  assign r_start  = rd_data[W-1 -: ADDR_BITS];
  assign r_t      = rd_data[3*CB-1 -: CB];
  assign r_fe     = rd_data[2*CB-1 -: CB];
  assign r_ft     = rd_data[CB-1:0];
  assign mid      = lo + ((hi - lo) >> 1);
  assign lb_eq    = (lo < region_count) && (r_start == addr_q);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  assign idx_ok   = 32'(entry_index) < 32'(region_count);
  assign tgt_ok   = CW'(foreign_target) < region_count;

  assign n_t  = (op == OP_TICK   && r_t  != '1) ? r_t  + 1'b1 : r_t;
  assign n_fe = (op == OP_FENTER && r_fe != '1) ? r_fe + 1'b1 : r_fe;
  assign n_ft = (op == OP_FTICK  && r_ft != '1) ? r_ft + 1'b1 : r_ft;

  psrp_mem #(
    .DEPTH(REGIONS),
    .WIDTH(W)
  ) u_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_LOAD, CMD_FENTER: state_next = S_LB;
            CMD_TICK: begin
              if (in_foreign && tgt_ok) begin
                state_next = S_USE;
              end else if (!in_foreign && !collector_active) begin
                state_next = S_LB;
              end else begin
                state_next = S_FIN;
              end
            end
            CMD_READ: state_next = idx_ok ? S_USE : S_FIN;
            default: state_next = S_FIN;
          endcase
        end
      end
      S_LB: state_next = (lo < hi) ? S_LBCMP : S_CHK;
      S_LBCMP: state_next = S_LB;
      S_CHK: begin
        if (op == OP_LOAD) begin
          if (lb_eq || region_count == CW'(REGIONS)) begin
            state_next = S_FIN;
          end else begin
            state_next = S_SHRD;
          end
        end else if (lb_eq || lo != '0) begin
          state_next = S_USE;
        end else begin
          state_next = S_FIN;
        end
      end
      S_USE: state_next = S_FIN;
      S_SHRD: state_next = (sh > lo) ? S_SHWR : S_FIN;
      S_SHWR: state_next = S_SHRD;
      S_FIN: state_next = out_free ? S_IDLE : S_FIN;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && cmd == CMD_TICK && in_foreign && tgt_ok) begin
          rd_en   = 1'b1;
          rd_addr = foreign_target;
        end else if (in_valid && cmd == CMD_READ && idx_ok) begin
          rd_en   = 1'b1;
          rd_addr = IW'(entry_index);
        end
      end
      S_LB: begin
        if (lo < hi) begin
          rd_en   = 1'b1;
          rd_addr = IW'(mid);
        end else if (lo < region_count) begin
          rd_en   = 1'b1;
          rd_addr = IW'(lo);
        end
      end
      S_CHK: begin
        if (op != OP_LOAD && !lb_eq && lo != '0) begin
          rd_en   = 1'b1;
          rd_addr = IW'(lo - CW'(1));
        end
      end
      S_USE: begin
        if (op != OP_READ) begin
          wr_en   = 1'b1;
          wr_addr = pos;
          wr_data = {r_start, n_t, n_fe, n_ft};
        end
      end
      S_SHRD: begin
        if (sh > lo) begin
          rd_en   = 1'b1;
          rd_addr = IW'(sh - CW'(1));
        end else begin
          wr_en   = 1'b1;
          wr_addr = IW'(lo);
          wr_data = {addr_q, {(3*CB){1'b0}}};
        end
      end
      S_SHWR: begin
        wr_en   = 1'b1;
        wr_addr = IW'(sh);
        wr_data = rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      region_count     <= '0;
      in_foreign       <= 1'b0;
      foreign_target   <= '0;
      collector_active <= 1'b0;
      gc_enter_total   <= '0;
      gc_tick_total    <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        case (cmd)
          CMD_TICK: begin
            if (!in_foreign && collector_active && gc_tick_total != '1) begin
              gc_tick_total <= gc_tick_total + 1'b1;
            end
          end
          CMD_FEXIT: in_foreign <= 1'b0;
          CMD_COLL: begin
            collector_active <= !collector_active;
            if (!collector_active && gc_enter_total != '1) begin
              gc_enter_total <= gc_enter_total + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (state == S_USE && op == OP_FENTER) begin
        in_foreign     <= 1'b1;
        foreign_target <= pos;
      end
      if (state == S_SHRD && !(sh > lo)) begin
        region_count <= region_count + 1'b1;
        if (CW'(foreign_target) >= lo && tgt_ok) begin
          foreign_target <= foreign_target + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_q     <= ADDR_BITS'(address);
      lo         <= '0;
      hi         <= region_count;
      res_status <= ST_OK;
      res_hit    <= '0;
      res_t      <= '0;
      res_fe     <= '0;
      res_ft     <= '0;
      case (cmd)
        CMD_LOAD:   op <= OP_LOAD;
        CMD_FENTER: op <= OP_FENTER;
        CMD_TICK: begin
          op  <= in_foreign ? OP_FTICK : OP_TICK;
          pos <= foreign_target;
          if (in_foreign && !tgt_ok) begin
            res_status <= ST_BELOW;
          end
        end
        CMD_READ: begin
          op  <= OP_READ;
          pos <= IW'(entry_index);
          if (!idx_ok) begin
            res_status <= ST_BELOW;
            res_hit    <= entry_index;
          end
        end
        default: op <= OP_READ;
      endcase
    end
    case (state)
      S_LBCMP: begin
        if (r_start < addr_q) begin
          lo <= mid + 1'b1;
        end else begin
          hi <= mid;
        end
      end
      S_CHK: begin
        sh <= region_count;
        if (op == OP_LOAD) begin
          if (lb_eq) begin
            res_status <= ST_DUP;
            res_hit    <= 8'(lo);
            res_t      <= r_t;
            res_fe     <= r_fe;
            res_ft     <= r_ft;
          end else if (region_count == CW'(REGIONS)) begin
            res_status <= ST_FULL;
          end
        end else if (lb_eq) begin
          pos <= IW'(lo);
        end else if (lo != '0) begin
          pos <= IW'(lo - CW'(1));
        end else begin
          res_status <= ST_BELOW;
        end
      end
      S_USE: begin
        res_hit <= 8'(pos);
        res_t   <= n_t;
        res_fe  <= n_fe;
        res_ft  <= n_ft;
      end
      S_SHRD: begin
        if (!(sh > lo)) begin
          res_hit <= 8'(lo);
        end
      end
      S_SHWR: sh <= sh - 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      status           <= res_status;
      hit_index        <= res_hit;
      tick_count       <= 32'(res_t);
      foreign_enters   <= 32'(res_fe);
      foreign_ticks    <= 32'(res_ft);
      collector_enters <= 32'(gc_enter_total);
      collector_ticks  <= 32'(gc_tick_total);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(region_count) <= 32'(REGIONS))
    else $error("region count exceeds table size");

  a_target_valid: assert property (@(posedge clk) disable iff (rst)
    in_foreign |-> tgt_ok)
    else $error("foreign target outside filled table");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> state == S_FIN)
    else $error("result dropped while out beat stalled");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted beat not processed");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SHWR |-> (sh > lo && sh <= region_count))
    else $error("insert shift out of range");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import psrp_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    status_t     status;
    logic [7:0]  hit;
    logic [31:0] ticks;
    logic [31:0] fenters;
    logic [31:0] fticks;
    logic [31:0] genters;
    logic [31:0] gticks;
  } beat_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  cmd;
  logic [31:0] address;
  logic [7:0]  entry_index;
  logic        out_valid;
  logic        out_ready;
  status_t     status;
  logic [7:0]  hit_index;
  logic [31:0] tick_count;
  logic [31:0] foreign_enters;
  logic [31:0] foreign_ticks;
  logic [31:0] collector_enters;
  logic [31:0] collector_ticks;

  pc_sample_region_profiler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .address(address), .entry_index(entry_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .hit_index(hit_index), .tick_count(tick_count),
    .foreign_enters(foreign_enters), .foreign_ticks(foreign_ticks),
    .collector_enters(collector_enters), .collector_ticks(collector_ticks)
  );

  // profile table mirror
  logic [31:0] prof_start [TABLE_DEPTH];
  logic [31:0] prof_ticks [TABLE_DEPTH];
  logic [31:0] prof_fent  [TABLE_DEPTH];
  logic [31:0] prof_ftick [TABLE_DEPTH];
  int          prof_count;
  bit          prof_in_foreign;
  int          prof_target;
  bit          prof_coll_on;
  logic [31:0] prof_gc_enters;
  logic [31:0] prof_gc_ticks;

  beat_t pending_beats[$];
  int    error_count;
  int    send_gap_max;
  int    recv_gap_max;
  int    recv_hold;
  int    idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int count_below(logic [31:0] addr);
    int n;
    n = 0;
    while (n < prof_count && prof_start[n] < addr) n++;
    return n;
  endfunction

  function automatic void fill_entry(ref beat_t b, input int pos);
    b.hit     = pos[7:0];
    b.ticks   = prof_ticks[pos];
    b.fenters = prof_fent[pos];
    b.fticks  = prof_ftick[pos];
  endfunction

  function automatic beat_t predict_beat(logic [2:0] c, logic [31:0] addr, logic [7:0] idx);
    beat_t b;
    int    pos;
    b = '{ST_OK, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    pos = count_below(addr);
    case (c)
      CMD_LOAD: begin
        if (pos < prof_count && prof_start[pos] == addr) begin
          b.status = ST_DUP;
          fill_entry(b, pos);
        end else if (prof_count >= TABLE_DEPTH) begin
          b.status = ST_FULL;
        end else begin
          for (int i = prof_count; i > pos; i--) begin
            prof_start[i] = prof_start[i-1];
            prof_ticks[i] = prof_ticks[i-1];
            prof_fent[i]  = prof_fent[i-1];
            prof_ftick[i] = prof_ftick[i-1];
          end
          prof_start[pos] = addr;
          prof_ticks[pos] = '0;
          prof_fent[pos]  = '0;
          prof_ftick[pos] = '0;
          prof_count++;
          if (prof_target >= pos && prof_target + 1 < prof_count) prof_target++;
          fill_entry(b, pos);
        end
      end
      CMD_TICK, CMD_FENTER: begin
        if (c == CMD_TICK && prof_in_foreign) begin
          if (prof_target < prof_count) begin
            prof_ftick[prof_target] = sat_inc(prof_ftick[prof_target]);
            fill_entry(b, prof_target);
          end else begin
            b.status = ST_BELOW;
          end
        end else if (c == CMD_TICK && prof_coll_on) begin
          prof_gc_ticks = sat_inc(prof_gc_ticks);
        end else begin
          if (!(pos < prof_count && prof_start[pos] == addr)) pos--;
          if (pos < 0) begin
            b.status = ST_BELOW;
          end else if (c == CMD_TICK) begin
            prof_ticks[pos] = sat_inc(prof_ticks[pos]);
            fill_entry(b, pos);
          end else begin
            prof_fent[pos] = sat_inc(prof_fent[pos]);
            prof_target = pos;
            prof_in_foreign = 1'b1;
            fill_entry(b, pos);
          end
        end
      end
      CMD_FEXIT: prof_in_foreign = 1'b0;
      CMD_COLL: begin
        if (prof_coll_on) begin
          prof_coll_on = 1'b0;
        end else begin
          prof_coll_on = 1'b1;
          prof_gc_enters = sat_inc(prof_gc_enters);
        end
      end
      CMD_READ: begin
        if (32'(idx) < prof_count) begin
          fill_entry(b, 32'(idx));
        end else begin
          b.status = ST_BELOW;
          b.hit = idx;
        end
      end
      default: ;
    endcase
    b.genters = prof_gc_enters;
    b.gticks  = prof_gc_ticks;
    return b;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  task automatic send_beat(logic [2:0] c, logic [31:0] addr, logic [7:0] idx);
    int gap;
    gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd         <= c;
    address     <= addr;
    entry_index <= idx;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_beats.push_back(predict_beat(c, addr, idx));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_address();
    int k;
    if (prof_count == 0 || $urandom_range(0, 1) == 0) return $urandom;
    k = $urandom_range(0, prof_count - 1);
    return prof_start[k] + $urandom_range(0, 3) - ($urandom_range(0, 3) == 0 ? 1 : 0);
  endfunction

  // receiver
  initial begin
    int    stall;
    beat_t want;
    out_ready <= 1'b0;
    forever begin
      if (recv_hold > 0) begin
        out_ready <= 1'b0;
        repeat (recv_hold) @(posedge clk);
        recv_hold = 0;
      end else begin
        stall = (recv_gap_max == 0) ? 0 : $urandom_range(0, recv_gap_max);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      if (pending_beats.size() == 0) begin
        $display("unexpected beat at %0t", $realtime);
        error_count++;
      end else begin
        want = pending_beats.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (hit_index !== want.hit) report_mismatch("hit_index", hit_index, want.hit);
        if (tick_count !== want.ticks) report_mismatch("tick_count", tick_count, want.ticks);
        if (foreign_enters !== want.fenters)
          report_mismatch("foreign_enters", foreign_enters, want.fenters);
        if (foreign_ticks !== want.fticks)
          report_mismatch("foreign_ticks", foreign_ticks, want.fticks);
        if (collector_enters !== want.genters)
          report_mismatch("collector_enters", collector_enters, want.genters);
        if (collector_ticks !== want.gticks)
          report_mismatch("collector_ticks", collector_ticks, want.gticks);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_empty_table();
    send_beat(CMD_TICK, 32'h0, 8'd0);
    send_beat(CMD_FENTER, 32'hFFFF_FFFF, 8'd0);
    send_beat(CMD_READ, 32'h0, 8'd0);
    send_beat(CMD_READ, 32'h0, 8'd255);
    send_beat(CMD_FEXIT, 32'h0, 8'd0);
    send_beat(3'd6, 32'h0, 8'd0);
    send_beat(3'd7, 32'hFFFF_FFFF, 8'd255);
    send_beat(CMD_COLL, 32'h0, 8'd0);
    send_beat(CMD_COLL, 32'h0, 8'd0);
  endtask

  task automatic test_directed();
    send_beat(CMD_LOAD, 32'h8000_0000, 8'd0);
    send_beat(CMD_LOAD, 32'h0000_1000, 8'd0);
    send_beat(CMD_LOAD, 32'hFFFF_FFFF, 8'd0);
    send_beat(CMD_LOAD, 32'h0000_1000, 8'd0);
    send_beat(CMD_TICK, 32'h0000_0000, 8'd0);
    send_beat(CMD_TICK, 32'hFFFF_FFFF, 8'd0);
    send_beat(CMD_TICK, 32'h8000_0001, 8'd0);
    send_beat(CMD_FENTER, 32'h9000_0000, 8'd0);
    send_beat(CMD_TICK, 32'h0000_0000, 8'd0);
    send_beat(CMD_LOAD, 32'h0000_0000, 8'd0);
    send_beat(CMD_TICK, 32'h0000_2000, 8'd0);
    send_beat(CMD_COLL, 32'h0, 8'd0);
    send_beat(CMD_TICK, 32'h0000_2000, 8'd0);
    send_beat(CMD_FEXIT, 32'h0, 8'd0);
    send_beat(CMD_TICK, 32'h0000_2000, 8'd0);
    send_beat(CMD_COLL, 32'h0, 8'd0);
    send_beat(CMD_FENTER, 32'h0000_0FFF, 8'd0);
    for (int i = 0; i < 4; i++) send_beat(CMD_READ, 32'h0, i[7:0]);
    send_beat(CMD_READ, 32'h0, 8'd200);
  endtask

  task automatic test_random_mix(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
        recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
      end
      r = $urandom_range(0, 99);
      if (r < 12 && prof_count < 230) send_beat(CMD_LOAD, $urandom, 8'($urandom));
      else if (r < 50) send_beat(CMD_TICK, pick_address(), 8'($urandom));
      else if (r < 58) send_beat(CMD_FENTER, pick_address(), 8'($urandom));
      else if (r < 66) send_beat(CMD_FEXIT, $urandom, 8'($urandom));
      else if (r < 72) send_beat(CMD_COLL, $urandom, 8'($urandom));
      else if (r < 95)
        send_beat(CMD_READ, $urandom,
                  ($urandom_range(0, 1) == 0 && prof_count > 0) ?
                  8'($urandom_range(0, prof_count - 1)) : 8'($urandom_range(0, 255)));
      else send_beat(3'($urandom_range(6, 7)), $urandom, 8'($urandom));
    end
  endtask

  task automatic test_backpressure();
    drain_results();
    send_gap_max = 0;
    recv_hold = 400;
    for (int i = 0; i < 24; i++)
      send_beat((i % 2) ? CMD_READ : CMD_TICK, pick_address(), 8'($urandom));
    drain_results();
    recv_gap_max = 15;
    send_gap_max = 15;
  endtask

  task automatic test_full_table();
    logic [31:0] a;
    while (prof_count < TABLE_DEPTH) send_beat(CMD_LOAD, $urandom, 8'($urandom));
    do a = $urandom; while (count_below(a) < prof_count && prof_start[count_below(a)] == a);
    send_beat(CMD_LOAD, a, 8'd0);
    send_beat(CMD_LOAD, prof_start[0], 8'd0);
    send_beat(CMD_LOAD, prof_start[TABLE_DEPTH-1], 8'd0);
    send_beat(CMD_READ, 32'h0, 8'd255);
    send_beat(CMD_FENTER, prof_start[TABLE_DEPTH-1], 8'd0);
    send_beat(CMD_TICK, 32'h0, 8'd0);
    send_beat(CMD_FEXIT, 32'h0, 8'd0);
    for (int i = 0; i < 40; i++) send_beat(CMD_TICK, pick_address(), 8'($urandom));
  endtask

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    cmd          <= '0;
    address      <= '0;
    entry_index  <= '0;
    error_count  = 0;
    send_gap_max = 15;
    recv_gap_max = 15;
    recv_hold    = 0;
    prof_count   = 0;
    prof_in_foreign = 1'b0;
    prof_target  = 0;
    prof_coll_on = 1'b0;
    prof_gc_enters = '0;
    prof_gc_ticks  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_directed();
    test_random_mix(800);
    test_backpressure();
    test_random_mix(900);
    test_full_table();
    drain_results();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/psrp_pkg.sv
src/psrp_mem.sv
src/pc_sample_region_profiler.sv
verif/testbench.sv
